@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the sorted key table.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/skt_pkg.sv @@
// Package of the sorted key table: status and request codes, the command
// struct that the controller hands to every cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Command broadcast to the cell chain for one cycle.
    typedef struct packed {
        logic find_en;
        logic ins_en;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/skt_cell.sv @@
// One slot of the sorted key table: holds a key/value pair, compares it with
// the request key and shifts from its upper neighbour on insert. Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell
    import skt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    input  wire logic [KEY_W-1:0]   req_key,
    input  wire logic [VALUE_W-1:0] req_value,
    input  wire logic               prev_ge,
    input  wire logic [KEY_W-1:0]   prev_key,
    input  wire logic [VALUE_W-1:0] prev_value,
    input  wire logic               next_ge,
    output logic                    ge,
    output logic [KEY_W-1:0]        key_q,
    output logic [VALUE_W-1:0]      value_q,
    output logic                    hit
);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               hit_reg;
    logic               hit_next;
    logic               ins_here;

    assign ge       = (key_reg >= req_key);
    // The insert point is the first slot whose key is smaller than the new key.
    assign ins_here = !ge && prev_ge;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.ins_en)
        begin
            if (!prev_ge)
            begin
                key_next   = prev_key;
                value_next = prev_value;
            end
            else if (ins_here)
            begin
                key_next   = req_key;
                value_next = req_value;
            end
        end
        // A find hits the last slot of the run whose keys are at least the request, if its key is equal.
        hit_next = (cmd.find_en && ge && !next_ge && (key_reg == req_key)) ||
                   (cmd.ins_en && ins_here);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            value_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            key_reg   <= key_next;
            value_reg <= value_next;
            hit_reg   <= hit_next;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign hit     = hit_reg;

endmodule

`default_nettype wire

@@ src/skt_tree.sv @@
// Registered reduction tree that turns the one-hot hit flags of the cell chain
// into a slot number and that slot's value, one tree level per cycle. Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_tree
    import skt_pkg::*;
#(
    parameter int N = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [N-1:0]              hits,
    input  wire logic [N-1:0][VALUE_W-1:0] values,
    output logic                           done,
    output logic                           found,
    output logic [$clog2(N)-1:0]           index,
    output logic [VALUE_W-1:0]             value
);

    localparam int IDX_W = $clog2(N);
    localparam int P     = 1 << IDX_W;
    localparam int NODES = 2 * P - 1;

    // Heap order: node 0 is the root, children of n are 2n+1 and 2n+2.
    logic [NODES-1:0]   nv;
    logic [IDX_W-1:0]   ni   [NODES];
    logic [VALUE_W-1:0] nval [NODES];
    logic [P-2:0]       nv_reg;
    logic [IDX_W-1:0]   ni_reg   [P-1];
    logic [VALUE_W-1:0] nval_reg [P-1];
    logic [IDX_W-1:0]   tok_reg;
    logic [IDX_W:0]     tok_next;

    for (genvar k = 0; k < P; k++)
    begin : g_leaf
        assign ni[P-1+k] = IDX_W'(k);
        if (k < N)
        begin : g_used
            assign nv[P-1+k]   = hits[k];
            assign nval[P-1+k] = values[k];
        end
        else
        begin : g_pad
            assign nv[P-1+k]   = 1'b0;
            assign nval[P-1+k] = '0;
        end
    end

    for (genvar n = 0; n < P - 1; n++)
    begin : g_node
        assign nv[n]   = nv_reg[n];
        assign ni[n]   = ni_reg[n];
        assign nval[n] = nval_reg[n];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nv_reg[n] <= 1'b0;
            else
                nv_reg[n] <= nv[2*n+1] | nv[2*n+2];
        end

        always_ff @(posedge clk)
        begin
            if (nv[2*n+1])
            begin
                ni_reg[n]   <= ni[2*n+1];
                nval_reg[n] <= nval[2*n+1];
            end
            else
            begin
                ni_reg[n]   <= ni[2*n+2];
                nval_reg[n] <= nval[2*n+2];
            end
        end
    end

    // A token walks alongside the data so the root is sampled at the right cycle.
    assign tok_next = {tok_reg, start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next[IDX_W-1:0];
    end

    assign done  = tok_reg[IDX_W-1];
    assign found = nv[0];
    assign index = ni[0];
    assign value = nval[0];

endmodule

`default_nettype wire

@@ src/sorted_key_table_search_insert_core.sv @@
// Top level of the sorted key table: request handling, the chain of slot cells
// and the hit reduction tree. Uses skt_pkg, skt_cell and skt_tree.
//
//  channel  | direction | tdata (low bit up)     | tuser
//  ---------+-----------+------------------------+----------
//  s_*      | in        | key[31:0], value[31:0] | req_type
//  m_*      | out       | status[1:0], slot_index[5:0], found_value[31:0] | -
//
// One request is in flight at a time; from the input beat to the result beat it passes
// through the cell compare, the registered levels of the hit reduction tree, the result
// capture register and the output register.
// The next request beat is taken while an earlier result beat still waits.
// Reset empties every slot at once; a stalled result holds the controller
// before it presents the following one.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_search_insert_core
    import skt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status[1:0], slot_index[7:2], found_value[39:8]
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic                 req_type_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 ins_ok_reg;
    logic [STAT_W-1:0]    refuse_reg;
    logic                 start_reg;
    logic [STAT_W-1:0]    res_status_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [VALUE_W-1:0]   res_value_reg;
    logic                 m_tvalid_reg;
    logic [39:0]          m_tdata_reg;

    logic                 s_fire;
    logic                 out_free;
    logic                 ins_ok;
    cmd_t                 cmd;
    logic [CAPACITY-1:0]  ge;
    logic [CAPACITY-1:0]  hits;
    logic [CAPACITY-1:0][KEY_W-1:0]   keys;
    logic [CAPACITY-1:0][VALUE_W-1:0] vals;
    logic                 tree_done;
    logic                 tree_found;
    logic [IDX_W-1:0]     tree_index;
    logic [VALUE_W-1:0]   tree_value;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ins_ok = (req_type_reg == REQ_INSERT) && (key_reg != '0) &&
                    (cnt_reg != CNT_W'(CAPACITY));
    assign cmd.ins_en  = (state_reg == S_EXEC) && ins_ok;
    assign cmd.find_en = (state_reg == S_EXEC) && (req_type_reg == REQ_FIND) &&
                         (key_reg != '0);
    assign cnt_next    = cmd.ins_en ? cnt_reg + CNT_W'(1) : cnt_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic               prev_ge;
        logic [KEY_W-1:0]   prev_key;
        logic [VALUE_W-1:0] prev_value;
        logic               next_ge;

        if (i == 0)
        begin : g_first
            assign prev_ge    = 1'b1;
            assign prev_key   = '0;
            assign prev_value = '0;
        end
        else
        begin : g_mid
            assign prev_ge    = ge[i-1];
            assign prev_key   = keys[i-1];
            assign prev_value = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_ge = 1'b0;
        end
        else
        begin : g_inner
            assign next_ge = ge[i+1];
        end

        skt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .req_key    (key_reg),
            .req_value  (value_reg),
            .prev_ge    (prev_ge),
            .prev_key   (prev_key),
            .prev_value (prev_value),
            .next_ge    (next_ge),
            .ge         (ge[i]),
            .key_q      (keys[i]),
            .value_q    (vals[i]),
            .hit        (hits[i])
        );
    end

    skt_tree #(
        .N (CAPACITY)
    ) u_tree (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .hits   (hits),
        .values (vals),
        .done   (tree_done),
        .found  (tree_found),
        .index  (tree_index),
        .value  (tree_value)
    );

    // Slot numbers wider than the result field keep only their low bits.
    assign slot_ext = {{SLOT_W{1'b0}}, tree_index};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_fire) state_next = S_EXEC;
            S_EXEC: state_next = S_WAIT;
            S_WAIT: if (tree_done) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            start_reg <= (state_reg == S_EXEC);
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_type_reg <= s_tuser;
            key_reg      <= s_tdata[31:0];
            value_reg    <= s_tdata[63:32];
        end
        if (state_reg == S_EXEC)
        begin
            ins_ok_reg <= ins_ok;
            refuse_reg <= (key_reg == '0) ? ST_MISS : ST_FULL;
        end
        if (state_reg == S_WAIT && tree_done)
        begin
            if (req_type_reg == REQ_FIND)
            begin
                res_status_reg <= tree_found ? ST_OK : ST_MISS;
                res_slot_reg   <= tree_found ? slot_ext[SLOT_W-1:0] : '0;
                res_value_reg  <= tree_found ? tree_value : '0;
            end
            else
            begin
                res_status_reg <= ins_ok_reg ? ST_OK : refuse_reg;
                res_slot_reg   <= ins_ok_reg ? slot_ext[SLOT_W-1:0] : '0;
                res_value_reg  <= '0;
            end
        end
        if (state_reg == S_DONE && out_free)
            m_tdata_reg <= {res_value_reg, res_slot_reg, res_status_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ src/skt_checker.sv @@
// Port-level checker for the sorted key table core, bound to the top level.
// Depends on assert_macros.svh and on the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module skt_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata
);

    // A result beat that is held back keeps its contents.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The status code three is never produced.
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3)

    // Misses and refused inserts carry a zero slot and a zero value.
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, m_tvalid && (m_tdata[1:0] != 2'd0),
                    m_tdata[39:2] == 38'd0)

    // Only one request is worked on at a time.
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind sorted_key_table_search_insert_core skt_checker u_skt_checker (.*);

`default_nettype wire

@@ tb/sv/tb_sorted_key_table_search_insert_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sorted key table core: directed rows, then random
// find and insert requests checked against a local shadow of the table.
// Depends on skt_pkg and sorted_key_table_search_insert_core.

module tb_sorted_key_table_search_insert_core;
    import skt_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1950;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } reply_t;

    typedef struct {
        logic               req;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        reply_t             want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key[31:0], value[63:32]
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status[1:0], slot_index[7:2], found_value[39:8]

    // Shadow copy of the table, advanced as each request beat is accepted.
    logic [KEY_W-1:0]   shadow_keys [CAPACITY];
    logic [VALUE_W-1:0] shadow_vals [CAPACITY];
    int unsigned        shadow_count;

    reply_t awaited_replies[$];
    row_t   directed_rows[$];
    int     error_count;
    int     idle_cycles;
    int     send_quiet;
    int     recv_quiet;

    sorted_key_table_search_insert_core #(.CAPACITY(CAPACITY)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic reply_t search_table(input logic [KEY_W-1:0] key);
        reply_t r;
        int     pos;
        bit     any;
        r   = '{ST_MISS, '0, '0};
        pos = 0;
        any = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_keys[i] >= key)
            begin
                pos = i;
                any = 1'b1;
            end
        end
        if (key != '0 && any && shadow_keys[pos] == key)
            r = '{ST_OK, pos[SLOT_W-1:0], shadow_vals[pos]};
        return r;
    endfunction

    function automatic reply_t insert_into_table(input logic [KEY_W-1:0] key,
                                                 input logic [VALUE_W-1:0] value);
        if (key == '0)
            return '{ST_MISS, '0, '0};
        if (shadow_count >= CAPACITY)
            return '{ST_FULL, '0, '0};
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (key > shadow_keys[i])
            begin
                for (int j = CAPACITY - 1; j > i; j--)
                begin
                    shadow_keys[j] = shadow_keys[j-1];
                    shadow_vals[j] = shadow_vals[j-1];
                end
                shadow_keys[i] = key;
                shadow_vals[i] = value;
                shadow_count++;
                return '{ST_OK, i[SLOT_W-1:0], '0};
            end
        end
        return '{ST_FULL, '0, '0};
    endfunction

    // Idle cycles before the next beat; now and then a run of beats with no idling.
    function automatic int draw_idle(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0)
            quiet_left = $urandom_range(20, 60);
        return $urandom_range(0, 6);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Entered and left at a falling edge.
    task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value, input bit typed,
                                input reply_t want);
        int     gap;
        reply_t r;
        gap = draw_idle(send_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {value, key};
        do
            @(posedge clk);
        while (!s_tready);
        if (req == REQ_INSERT)
            r = insert_into_table(key, value);
        else
            r = search_table(key);
        awaited_replies.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // Result side: random stalls, each beat compared field by field.
    initial
    begin
        int     stall;
        reply_t got;
        reply_t want;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_idle(recv_quiet);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = '{m_tdata[1:0], m_tdata[7:2], m_tdata[39:8]};
            if (awaited_replies.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending: %h", m_tdata));
            else
            begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              got.slot, want.slot));
                if (got.value !== want.value)
                    report_mismatch($sformatf("found_value %h, expected %h",
                                              got.value, want.value));
            end
            @(negedge clk);
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("tb_sorted_key_table_search_insert_core failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int               sel;
        logic             req;
        logic [KEY_W-1:0] key;
        row_t             row;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        send_quiet   = 0;
        recv_quiet   = 0;
        shadow_count = 0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            shadow_keys[i] = '0;
            shadow_vals[i] = '0;
        end

        // Empty table, reserved key, extreme keys and values, duplicates at both ends.
        directed_rows.push_back('{REQ_FIND,   32'h0000_0000, 32'h0, 1, '{ST_MISS, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'hFFFF_FFFF, 32'h0, 1, '{ST_MISS, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h0000_0001, 32'h0, 1, '{ST_MISS, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1,
                                  '{ST_MISS, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 1, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 1,
                                  '{ST_OK, 1, 0}});
        directed_rows.push_back('{REQ_FIND,   32'hFFFF_FFFF, 32'h0, 1, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h0000_0001, 32'hFFFF_FFFF, 1,
                                  '{ST_OK, 1, 32'hFFFF_FFFF}});
        directed_rows.push_back('{REQ_FIND,   32'h0000_0000, 32'h0, 1, '{ST_MISS, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 1,
                                  '{ST_OK, 1, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h8000_0001, 32'h0, 0, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h7FFF_FFFF, 32'h0, 0, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 1,
                                  '{ST_OK, 2, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h8000_0000, 32'h0, 1,
                                  '{ST_OK, 2, 32'h5A5A_5A5A}});
        directed_rows.push_back('{REQ_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1,
                                  '{ST_OK, 1, 0}});
        directed_rows.push_back('{REQ_FIND,   32'hFFFF_FFFF, 32'h0, 1,
                                  '{ST_OK, 1, 32'h1234_5678}});
        directed_rows.push_back('{REQ_INSERT, 32'h0000_0001, 32'h0, 0, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h0000_0001, 32'h0, 0, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'h0000_0002, 32'hDEAD_BEEF, 0,
                                  '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h0000_0002, 32'h0, 0, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_FIND,   32'h0000_0003, 32'h0, 0, '{ST_OK, 0, 0}});
        directed_rows.push_back('{REQ_INSERT, 32'h0000_0000, 32'h0, 1, '{ST_MISS, 0, 0}});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.req, row.key, row.value, row.typed, row.want);
        end

        // Find-leaning mix with 35 percent inserts, which fills the table and then runs on
        // against a full table; keys favour stored ones and their neighbours so that hits and
        // duplicates are common.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            req = ($urandom_range(0, 99) < 35) ? REQ_INSERT : REQ_FIND;
            sel = $urandom_range(0, 9);
            if (sel <= 4 && shadow_count > 0)
            begin
                key = shadow_keys[$urandom_range(0, shadow_count - 1)];
                if (sel == 4)
                    key = $urandom_range(0, 1) ? key + 1 : key - 1;
            end
            else if (sel == 5)
                key = '0;
            else if (sel == 6)
                key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            else
                key = $urandom;
            send_request(req, key, $urandom, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_sorted_key_table_search_insert_core passed");
        else
            $display("tb_sorted_key_table_search_insert_core failed");
        $finish;
    end

endmodule

@@ sorted_key_table_search_insert_core.f @@
+incdir+src
src/skt_pkg.sv
src/skt_cell.sv
src/skt_tree.sv
src/sorted_key_table_search_insert_core.sv
src/skt_checker.sv
tb/sv/tb_sorted_key_table_search_insert_core.sv
